FILE: rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque block.
package bdq_pkg;

  localparam int WORD_W      = 32;
  localparam int MAX_RESULTS = 32;
  localparam int LIST_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [3:0] {
    ACT_PUSH_FRONT = 4'd0,
    ACT_PUSH_BACK  = 4'd1,
    ACT_POP_FRONT  = 4'd2,
    ACT_POP_BACK   = 4'd3,
    ACT_DELETE     = 4'd4,
    ACT_CLEAR      = 4'd5,
    ACT_LIST_ALL   = 4'd6,
    ACT_FIRST_N    = 4'd7,
    ACT_LAST_N     = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_LOUT,
    S_SRCH,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        status;
    logic              last;
  } res_t;

endpackage

FILE: rtl/bdq_out.sv
// Output register stage for result transactions.
module bdq_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  bdq_pkg::res_t res,
  output logic          free,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata,   // word
  output logic [1:0]    m_tuser,   // status
  output logic          m_tlast
);
  import bdq_pkg::*;

  res_t hold;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      hold <= res;
    end
  end

  assign m_tdata = hold.word;
  assign m_tuser = hold.status;
  assign m_tlast = hold.last;

endmodule

FILE: rtl/bounded_deque_with_value_delete.sv
// Bounded deque with value delete: top level, store and sequencer.
// Push, clear, failed ops and ignored codes: one result, loaded into the output register from
// S_RESP once it is free. Pop and listings: the first word is read at accept, then S_LOUT gives
// one result per cycle while the output register is free, set by the single read port of the store.
// Value delete: S_SRCH searches from the front up to the match, then S_SHIFT moves each later entry down.
// Next input is taken once the last result sits in the output register.
// Synchronous reset empties the deque at once; the store itself is not cleared.
module bounded_deque_with_value_delete #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], count[37:32], zero pad
  input  logic [3:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // word
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast
);
  import bdq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = (CW > 6) ? CW : 6;

  // circular store
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;

  state_t state, state_next;
  logic [IW-1:0] front;
  logic [CW-1:0] fill;
  logic [CW-1:0] cur;
  logic [CW-1:0] dst;
  logic          wpend;
  logic [LIST_W-1:0] remain;
  logic [WORD_W-1:0] value_q;
  logic [1:0]        resp_status;
  logic [1:0]        in_status;

  action_t           act;
  logic signed [WORD_W-1:0] in_value;
  logic [5:0]        in_count;
  logic              accept;
  logic              full, empty, match;
  logic [CW-1:0]     n_sel, lst_start;
  logic [LIST_W-1:0] lst_len;
  logic [NW-1:0]     cnt_x, fil_x;

  logic              re, we;
  logic [CW-1:0]     rpos, wpos;
  logic [IW-1:0]     raddr, waddr;
  logic [WORD_W-1:0] wdata;
  logic              res_load, out_free;
  res_t              res;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] f, input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(f) + (CW+1)'(pos);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return IW'(sum);
  endfunction

  assign act      = action_t'(s_tuser);
  assign in_value = s_tdata[31:0];
  assign in_count = s_tdata[37:32];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign match    = (rdata == value_q);

  // listing window
  always_comb begin
    cnt_x = NW'(in_count);
    fil_x = NW'(fill);
    if (act == ACT_LIST_ALL) begin
      n_sel = fill;
    end else begin
      n_sel = (cnt_x < fil_x) ? CW'(cnt_x) : fill;
    end
    lst_start = (act == ACT_LAST_N) ? fill - n_sel : '0;
    if (int'(n_sel) > MAX_RESULTS) begin
      lst_len = LIST_W'(MAX_RESULTS);
    end else begin
      lst_len = LIST_W'(n_sel);
    end
  end

  // status of the single result, set at accept; a delete sets it again when its search or shift ends
  always_comb begin
    case (act) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: in_status = full ? ST_FULL : ST_OK;
      ACT_POP_FRONT, ACT_POP_BACK, ACT_DELETE, ACT_LIST_ALL, ACT_FIRST_N, ACT_LAST_N:
        in_status = empty ? ST_EMPTY : ST_OK;
      default: in_status = ST_OK;
    endcase
  end

  assign raddr = slot(front, rpos);
  assign waddr = slot(front, wpos);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (act) inside
            ACT_POP_FRONT, ACT_POP_BACK: state_next = empty ? S_RESP : S_LOUT;
            ACT_DELETE:                  state_next = empty ? S_RESP : S_SRCH;
            ACT_LIST_ALL, ACT_FIRST_N, ACT_LAST_N:
              state_next = (lst_len == '0) ? S_RESP : S_LOUT;
            default:                     state_next = S_RESP;
          endcase
        end
      end
      S_RESP: if (out_free) state_next = S_IDLE;
      S_LOUT: if (out_free && remain == LIST_W'(1)) state_next = S_IDLE;
      S_SRCH: begin
        if (match) begin
          state_next = S_SHIFT;
        end else if (cur == fill) begin
          state_next = S_RESP;
        end
      end
      S_SHIFT: if (cur == fill && !wpend) state_next = S_RESP;
      default: state_next = S_IDLE;
    endcase
  end

  // store port and result controls
  always_comb begin
    re       = 1'b0;
    we       = 1'b0;
    rpos     = cur;
    wpos     = dst;
    wdata    = rdata;
    res_load = 1'b0;
    res      = '{word: '0, status: ST_OK, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (act) inside
            ACT_PUSH_FRONT: begin
              we    = !full;
              wpos  = CW'(DEPTH - 1);
              wdata = in_value;
            end
            ACT_PUSH_BACK: begin
              we    = !full;
              wpos  = fill;
              wdata = in_value;
            end
            ACT_POP_FRONT, ACT_DELETE: begin
              re   = !empty;
              rpos = '0;
            end
            ACT_POP_BACK: begin
              re   = !empty;
              rpos = fill - CW'(1);
            end
            ACT_LIST_ALL, ACT_FIRST_N, ACT_LAST_N: begin
              re   = (lst_len != '0);
              rpos = lst_start;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        res_load   = out_free;
        res.status = resp_status;
      end
      S_LOUT: begin
        res_load = out_free;
        res.word = rdata;
        res.last = (remain == LIST_W'(1));
        re       = out_free && (remain != LIST_W'(1));
      end
      S_SRCH:  re = !match && (cur != fill);
      S_SHIFT: begin
        re = (cur != fill);
        we = wpend;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      fill  <= '0;
      wpend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value_q     <= in_value;
            resp_status <= in_status;
            case (act) inside
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (!full) begin
                  fill <= fill + CW'(1);
                  if (act == ACT_PUSH_FRONT) front <= waddr;
                end
              end
              ACT_POP_FRONT, ACT_POP_BACK: begin
                remain <= LIST_W'(1);
                if (!empty) begin
                  fill <= fill - CW'(1);
                  if (act == ACT_POP_FRONT) begin
                    front <= (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
                  end
                end
              end
              ACT_DELETE: begin
                cur <= CW'(1);
              end
              ACT_CLEAR: begin
                fill  <= '0;
                front <= '0;
              end
              ACT_LIST_ALL, ACT_FIRST_N, ACT_LAST_N: begin
                remain <= lst_len;
                cur    <= lst_start + CW'(1);
              end
              default: ;
            endcase
          end
        end
        S_RESP: ;
        S_LOUT: begin
          if (out_free) begin
            remain <= remain - LIST_W'(1);
            cur    <= cur + CW'(1);
          end
        end
        S_SRCH: begin
          wpend <= 1'b0;
          if (!match) begin
            if (cur == fill) begin
              resp_status <= ST_NOTFOUND;
            end else begin
              cur <= cur + CW'(1);
            end
          end
        end
        S_SHIFT: begin
          // entry at cur moves down to cur-1 in the cycle after its read
          wpend <= re;
          if (re) begin
            dst <= cur - CW'(1);
            cur <= cur + CW'(1);
          end
          if (cur == fill && !wpend) begin
            fill        <= fill - CW'(1);
            resp_status <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  bdq_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  a_shift_ports: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("read and write hit the same entry");

  a_srch_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH || state == S_SHIFT) |-> (fill != '0))
    else $error("delete running on an empty deque");

  a_list_remain: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOUT) |-> (remain != '0))
    else $error("listing with nothing left to emit");

endmodule

FILE: tb/bounded_deque_with_value_delete_tb.sv
// Self-checking testbench for the bounded deque with value delete.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete_tb;
  import bdq_pkg::*;

  localparam int DEPTH      = 32;
  localparam int SIW        = $clog2(DEPTH);
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int RANDOM_OPS = 200;

  typedef struct {
    logic [3:0]  action;
    logic [31:0] value;
    logic [5:0]  count;
    bit          hold_for_drain;  // wait until all results are back before sending
  } deque_req_t;

  typedef enum int {
    PH_FILL,
    PH_EMPTY_OUT,
    PH_MIXED,
    PH_DELETE
  } phase_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // value[31:0], count[37:32], zero pad
  logic [3:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // word
  logic [1:0]  m_tuser;        // status
  logic        m_tlast;

  bounded_deque_with_value_delete #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow deque state
  logic [31:0] shadow_words [DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_fill = 0;

  // slot in the shadow store for a running position
  function automatic logic [SIW-1:0] sidx(int unsigned p);
    return SIW'(p % DEPTH);
  endfunction

  deque_req_t pending_reqs[$];
  res_t       expected_results[$];

  int unsigned n_predicted = 0;
  int unsigned n_seen = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned n_full_hits = 0;
  int unsigned n_delete_hits = 0;
  int unsigned n_max_fill = 0;
  int unsigned cycle_cnt = 0;

  // during a recurring quiet stretch both sides run without gaps
  function automatic bit quiet_stretch();
    return ((cycle_cnt / 2000) % 4) == 3;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_stretch() || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic deque_req_t make_req(logic [3:0] act, logic [31:0] val,
                                          logic [5:0] cnt, bit hold);
    deque_req_t req;
    req.action = act;
    req.value  = val;
    req.count  = cnt;
    req.hold_for_drain = hold;
    return req;
  endfunction

  function automatic void add_expected(logic [31:0] word, logic [1:0] status, logic last);
    res_t r;
    r.word   = word;
    r.status = status;
    r.last   = last;
    expected_results.push_back(r);
    n_predicted++;
  endfunction

  function automatic void expect_listing(int unsigned first, int unsigned len);
    if (len > MAX_RESULTS) len = MAX_RESULTS;
    if (len == 0) begin
      add_expected('0, (shadow_fill == 0) ? ST_EMPTY : ST_OK, 1'b1);
    end else begin
      for (int unsigned k = 0; k < len; k++)
        add_expected(shadow_words[sidx(shadow_head + first + k)], ST_OK, k + 1 == len);
    end
  endfunction

  function automatic void predict_deque(deque_req_t req);
    int unsigned pos;
    int unsigned take;
    logic [31:0] popped;
    case (req.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          n_full_hits++;
          add_expected('0, ST_FULL, 1'b1);
        end else begin
          if (req.action == ACT_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_words[sidx(shadow_head)] = req.value;
          end else begin
            shadow_words[sidx(shadow_head + shadow_fill)] = req.value;
          end
          shadow_fill++;
          if (shadow_fill > n_max_fill) n_max_fill = shadow_fill;
          add_expected('0, ST_OK, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (shadow_fill == 0) begin
          add_expected('0, ST_EMPTY, 1'b1);
        end else begin
          if (req.action == ACT_POP_FRONT) begin
            popped = shadow_words[sidx(shadow_head)];
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            popped = shadow_words[sidx(shadow_head + shadow_fill - 1)];
          end
          shadow_fill--;
          add_expected(popped, ST_OK, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (shadow_fill == 0) begin
          add_expected('0, ST_EMPTY, 1'b1);
        end else begin
          pos = 0;
          while (pos < shadow_fill && shadow_words[sidx(shadow_head + pos)] != req.value)
            pos++;
          if (pos == shadow_fill) begin
            add_expected('0, ST_NOTFOUND, 1'b1);
          end else begin
            // later entries slide toward the front to close the gap
            for (; pos + 1 < shadow_fill; pos++)
              shadow_words[sidx(shadow_head + pos)] =
                shadow_words[sidx(shadow_head + pos + 1)];
            shadow_fill--;
            n_delete_hits++;
            add_expected('0, ST_OK, 1'b1);
          end
        end
      end
      ACT_CLEAR: begin
        shadow_fill = 0;
        shadow_head = 0;
        add_expected('0, ST_OK, 1'b1);
      end
      ACT_LIST_ALL: expect_listing(0, shadow_fill);
      ACT_FIRST_N: begin
        take = (req.count < shadow_fill) ? req.count : shadow_fill;
        expect_listing(0, take);
      end
      ACT_LAST_N: begin
        take = (req.count < shadow_fill) ? req.count : shadow_fill;
        expect_listing(shadow_fill - take, take);
      end
      default: add_expected('0, ST_OK, 1'b1);  // unused codes are ignored
    endcase
  endfunction

  // sender
  deque_req_t cur_req;
  int sender_gap = 0;

  always @(posedge clk) begin
    bit slot_free;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_deque(cur_req);
        n_accepted++;
      end
      slot_free = !s_tvalid || s_tready;
      if (slot_free) begin
        if (sender_gap > 0) begin
          sender_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold_for_drain && n_predicted != n_seen)) begin
          cur_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, cur_req.count, cur_req.value};
          s_tuser  <= cur_req.action;
          sender_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int sink_stall = 0;

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_seen <= n_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: word=%0d status=%0d last=%0b",
                 $signed(m_tdata), m_tuser, m_tlast);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.word) begin
            $error("word: expected %0d, got %0d", $signed(want.word), $signed(m_tdata));
            n_errors++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            n_errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            n_errors++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("bounded_deque_with_value_delete: mismatch");
      $finish;
    end
  end

  // a small pool makes deletes hit often and puts duplicates in the store
  function automatic logic [31:0] pick_value();
    logic [31:0] pool [8];
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h7, 32'h2A,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h55AA_55AA};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [5:0] pick_count();
    if ($urandom_range(0, 9) < 7) return 6'($urandom_range(0, 8));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [3:0] pick_action(phase_kind_t ph);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 4'($urandom_range(9, 15));
    if (r < 6) return ACT_CLEAR;
    case (ph)
      PH_FILL:      r = (r < 80) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      PH_EMPTY_OUT: r = (r < 65) ? $urandom_range(2, 3) : $urandom_range(0, 8);
      PH_DELETE:    r = (r < 45) ? ACT_DELETE :
                        (r < 75) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      default:      r = $urandom_range(0, 8);
    endcase
    if (r == ACT_CLEAR) r = ACT_LIST_ALL;  // clears come only from the early return above
    return 4'(r);
  endfunction

  initial begin
    deque_req_t req;
    phase_kind_t ph;
    int made;
    int phase_len;

    // empty store corner cases
    pending_reqs.push_back(make_req(ACT_POP_FRONT, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_POP_BACK, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_DELETE, 32'h2A, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_LIST_ALL, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_FIRST_N, '0, 6'd5, 1'b0));
    pending_reqs.push_back(make_req(ACT_LAST_N, '0, 6'd63, 1'b0));
    // field extremes at both ends
    pending_reqs.push_back(make_req(ACT_PUSH_FRONT, 32'h7FFF_FFFF, 6'd63, 1'b0));
    pending_reqs.push_back(make_req(ACT_PUSH_BACK, 32'h8000_0000, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_PUSH_FRONT, 32'h0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_PUSH_BACK, 32'hFFFF_FFFF, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_LIST_ALL, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_FIRST_N, '0, 6'd0, 1'b0));
    pending_reqs.push_back(make_req(ACT_FIRST_N, '0, 6'd2, 1'b0));
    pending_reqs.push_back(make_req(ACT_LAST_N, '0, 6'd3, 1'b0));
    pending_reqs.push_back(make_req(ACT_LAST_N, '0, 6'd63, 1'b0));
    pending_reqs.push_back(make_req(ACT_FIRST_N, '0, 6'd40, 1'b0));
    pending_reqs.push_back(make_req(ACT_DELETE, 32'd12345, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_DELETE, 32'h0, '0, 1'b0));
    pending_reqs.push_back(make_req(4'd9, 32'hFFFF_FFFF, 6'd63, 1'b0));
    pending_reqs.push_back(make_req(4'd15, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_POP_FRONT, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_POP_BACK, '0, '0, 1'b0));
    pending_reqs.push_back(make_req(ACT_CLEAR, '0, '0, 1'b1));
    pending_reqs.push_back(make_req(ACT_LIST_ALL, '0, '0, 1'b0));

    // random phases, each opened after the previous one has fully drained
    made = 0;
    while (made < RANDOM_OPS) begin
      ph = phase_kind_t'($urandom_range(0, 3));
      phase_len = (ph == PH_FILL) ? $urandom_range(30, 45) : $urandom_range(10, 30);
      for (int i = 0; i < phase_len; i++) begin
        req = make_req(pick_action(ph), pick_value(), pick_count(), i == 0);
        pending_reqs.push_back(req);
        made++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || s_tvalid || n_seen != n_predicted)
      @(negedge clk);
    repeat (80) @(negedge clk);

    $display("sent %0d transactions, checked %0d results; deepest fill %0d of %0d",
             n_accepted, n_seen, n_max_fill, DEPTH);
    $display("pushes refused when full: %0d, successful value deletes: %0d",
             n_full_hits, n_delete_hits);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("bounded_deque_with_value_delete: match");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d expected results never arrived", expected_results.size());
      $display("bounded_deque_with_value_delete: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bdq_pkg.sv
rtl/bdq_out.sv
rtl/bounded_deque_with_value_delete.sv
tb/bounded_deque_with_value_delete_tb.sv
